/* rtl/kcri_pkg.sv */
// kcri_pkg: shared types, constants and a helper function of the keyframe interpolator
// depends on nothing; used by kcri_ctrl, kcri_dp and the top level
package kcri_pkg;

	localparam int MAX_KEYS_DEF   = 8;
	localparam int VALUE_BITS_DEF = 16;
	localparam int KEY_W          = 16;   // stored field width, signed q3.12
	localparam int CW             = 22;   // spline coefficient / horner accumulator width
	localparam int T_W            = 16;   // t, unsigned q0.16
	localparam int PW             = CW + T_W + 1;

	typedef struct packed {
		logic signed [KEY_W-1:0] pos;
		logic signed [KEY_W-1:0] rx;
		logic signed [KEY_W-1:0] ry;
		logic signed [KEY_W-1:0] yo;
	} key_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic       wr;          // store the input keyframe
		logic       start;       // latch the query position
		logic       rd;          // read one table entry
		logic       take_clamp;  // result = entry just read, flagged
		logic       set_lo;      // lower segment bound = position just read
		logic       div_init;    // form numerator and denominator of t
		logic       div_step;    // one quotient bit
		logic       acc_en;      // add one tap into the coefficients
		logic [1:0] acc_tap;
		logic       h_load;      // horner accumulator = cubic coefficient
		logic       h_mul;
		logic       h_add;
		logic [1:0] h_stage;     // 0 quadratic, 1 linear, 2 constant term
		logic [1:0] val_sel;     // 0 x radius, 1 y radius, 2 y offset
		logic       publish;     // move result into the output register
	} cmd_t;

	typedef struct packed {
		logic q_le;   // query at or below entry just read
		logic q_ge;   // query at or above entry just read
		logic q_gt;   // query above entry just read
	} sts_t;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] d;
	} coef_t;

	// contribution of control point p (tap 0..3) to the four spline coefficients
	function automatic coef_t tap_terms(input logic [1:0] tap, input logic signed [KEY_W-1:0] p);
		logic signed [CW-1:0] x;
		coef_t r;
		x = CW'(p);
		r = '0;
		unique case (tap)
			2'd0: begin
				r.b = -x;
				r.c = x <<< 1;
				r.d = -x;
			end
			2'd1: begin
				r.a = x <<< 1;
				r.c = -((x <<< 2) + x);
				r.d = (x <<< 1) + x;
			end
			2'd2: begin
				r.b = x;
				r.c = x <<< 2;
				r.d = -((x <<< 1) + x);
			end
			default: begin
				r.c = -x;
				r.d = x;
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/kcri_dp.sv */
// kcri_dp: keyframe tables, segment bounds, t divider and horner evaluation
// depends on kcri_pkg; driven by commands from kcri_ctrl
module kcri_dp #(
	parameter int MAX_KEYS   = kcri_pkg::MAX_KEYS_DEF,
	parameter int VALUE_BITS = kcri_pkg::VALUE_BITS_DEF,
	localparam int AW = $clog2(MAX_KEYS)
) (
	input  logic                                  clk,
	input  kcri_pkg::cmd_t                        cmd,
	input  logic [AW-1:0]                         rd_addr,
	output kcri_pkg::sts_t                        sts,
	input  logic [2:0]                            key_index,
	input  logic signed [kcri_pkg::KEY_W-1:0]     key_position,
	input  logic signed [kcri_pkg::KEY_W-1:0]     key_radius_x,
	input  logic signed [kcri_pkg::KEY_W-1:0]     key_radius_y,
	input  logic signed [kcri_pkg::KEY_W-1:0]     key_offset_y,
	input  logic signed [kcri_pkg::KEY_W-1:0]     query_pos,
	output logic signed [kcri_pkg::KEY_W-1:0]     radius_x,
	output logic signed [kcri_pkg::KEY_W-1:0]     radius_y,
	output logic signed [kcri_pkg::KEY_W-1:0]     offset_y,
	output logic                                  clamped
);
	localparam int KW = kcri_pkg::KEY_W;
	localparam int CW = kcri_pkg::CW;
	localparam int TW = kcri_pkg::T_W;
	localparam int PW = kcri_pkg::PW;
	localparam logic signed [33:0] SAT_HI = 34'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
	localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

	kcri_pkg::key_t key_mem [MAX_KEYS];
	kcri_pkg::key_t rd_q;

	logic signed [KW-1:0] q_q;
	logic signed [KW-1:0] pos_lo_q;
	logic [TW-1:0]        rem_q, den_q, quo_q;
	logic                 t_zero_q, t_max_q;
	kcri_pkg::coef_t      coef_q [3];
	logic signed [CW-1:0] acc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [KW-1:0] res_q [3];
	logic                 res_cl_q;

	logic signed [KW:0]   num, den;
	logic [TW:0]          rem2;
	logic                 ge;
	logic [TW-1:0]        t_eff;
	logic signed [CW-1:0] h_coef, h_sum, h_half;
	logic signed [33:0]   h_ext, h_sat;
	logic signed [KW-1:0] tap_p [3];
	kcri_pkg::coef_t      tap_c [3];

	always_ff @(posedge clk) begin
		if (cmd.wr && (32'(key_index) < MAX_KEYS)) begin
			key_mem[AW'(32'(key_index))] <= '{pos: key_position, rx: key_radius_x,
				ry: key_radius_y, yo: key_offset_y};
		end
		if (cmd.rd) begin
			rd_q <= key_mem[rd_addr];
		end
	end

	assign sts.q_le = q_q <= rd_q.pos;
	assign sts.q_ge = q_q >= rd_q.pos;
	assign sts.q_gt = q_q > rd_q.pos;

	// segment numerator from the lower bound, denominator against the upper key just read
	assign num  = {q_q[KW-1], q_q} - {pos_lo_q[KW-1], pos_lo_q};
	assign den  = {rd_q.pos[KW-1], rd_q.pos} - {pos_lo_q[KW-1], pos_lo_q};
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};
	assign t_eff = t_zero_q ? '0 : (t_max_q ? '1 : quo_q);

	assign tap_p[0] = rd_q.rx;
	assign tap_p[1] = rd_q.ry;
	assign tap_p[2] = rd_q.yo;

	always_comb begin
		for (int v = 0; v < 3; v++) begin
			tap_c[v] = kcri_pkg::tap_terms(cmd.acc_tap, tap_p[v]);
		end
		unique case (cmd.h_stage)
			2'd0:    h_coef = coef_q[cmd.val_sel].c;
			2'd1:    h_coef = coef_q[cmd.val_sel].b;
			default: h_coef = coef_q[cmd.val_sel].a;
		endcase
		h_sum  = h_coef + CW'(prod_q >>> TW);
		h_half = h_sum >>> 1;
		h_ext  = 34'(h_half);
		if (h_ext > SAT_HI) begin
			h_sat = SAT_HI;
		end else if (h_ext < SAT_LO) begin
			h_sat = SAT_LO;
		end else begin
			h_sat = h_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			q_q <= query_pos;
		end
		if (cmd.set_lo) begin
			pos_lo_q <= rd_q.pos;
		end
		if (cmd.div_init) begin
			t_zero_q <= (num <= 0) || (den <= 0);
			t_max_q  <= (num > 0) && (den > 0) && (num >= den);
			rem_q    <= num[TW-1:0];
			den_q    <= den[TW-1:0];
			quo_q    <= '0;
			res_cl_q <= 1'b0;
			for (int v = 0; v < 3; v++) begin
				coef_q[v] <= '0;
			end
		end else if (cmd.div_step) begin
			rem_q <= ge ? TW'(rem2 - {1'b0, den_q}) : rem2[TW-1:0];
			quo_q <= {quo_q[TW-2:0], ge};
		end
		if (cmd.acc_en) begin
			for (int v = 0; v < 3; v++) begin
				coef_q[v].a <= coef_q[v].a + tap_c[v].a;
				coef_q[v].b <= coef_q[v].b + tap_c[v].b;
				coef_q[v].c <= coef_q[v].c + tap_c[v].c;
				coef_q[v].d <= coef_q[v].d + tap_c[v].d;
			end
		end
		if (cmd.h_load) begin
			acc_q <= coef_q[cmd.val_sel].d;
		end else if (cmd.h_add && cmd.h_stage != 2'd2) begin
			acc_q <= h_sum;
		end
		if (cmd.h_mul) begin
			prod_q <= acc_q * $signed({1'b0, t_eff});
		end
		if (cmd.h_add && cmd.h_stage == 2'd2) begin
			res_q[cmd.val_sel] <= h_sat[KW-1:0];
		end
		if (cmd.take_clamp) begin
			res_q[0] <= rd_q.rx;
			res_q[1] <= rd_q.ry;
			res_q[2] <= rd_q.yo;
			res_cl_q <= 1'b1;
		end
		if (cmd.publish) begin
			radius_x <= res_q[0];
			radius_y <= res_q[1];
			offset_y <= res_q[2];
			clamped  <= res_cl_q;
		end
	end

endmodule

/* rtl/kcri_ctrl.sv */
// kcri_ctrl: sequencer for load, range check, segment search, division and horner steps
// depends on kcri_pkg; commands kcri_dp
module kcri_ctrl #(
	parameter int MAX_KEYS = kcri_pkg::MAX_KEYS_DEF,
	localparam int AW = $clog2(MAX_KEYS),
	localparam int NW = $clog2(MAX_KEYS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [NW-1:0]   n_keys,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	output logic            out_valid,
	input  logic            out_stall,
	output kcri_pkg::cmd_t  cmd,
	output logic [AW-1:0]   rd_addr,
	input  kcri_pkg::sts_t  sts
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD1  = 4'd1;
	localparam logic [3:0] S_CK1  = 4'd2;
	localparam logic [3:0] S_RDK  = 4'd3;
	localparam logic [3:0] S_CKK  = 4'd4;
	localparam logic [3:0] S_RDS  = 4'd5;
	localparam logic [3:0] S_CKS  = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_HLD  = 4'd8;
	localparam logic [3:0] S_HMUL = 4'd9;
	localparam logic [3:0] S_HADD = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	localparam logic KIND_LOAD = 1'b1;

	logic [3:0]    state_q, state_d;
	logic [AW-1:0] seg_q, seg_d;
	logic [3:0]    cnt_q, cnt_d;
	logic [1:0]    val_q, val_d;
	logic [1:0]    stg_q, stg_d;
	logic          out_valid_q, out_valid_d;
	logic          more_seg;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign more_seg  = (NW'(seg_q) < (n_keys - NW'(3))) && sts.q_gt;

	always_comb begin
		state_d     = state_q;
		seg_d       = seg_q;
		cnt_d       = cnt_q;
		val_d       = val_q;
		stg_d       = stg_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '0;
		cmd.val_sel = val_q;
		cmd.h_stage = stg_q;
		rd_addr     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_LOAD) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = S_RD1;
					end
				end
			end
			S_RD1: begin
				cmd.rd  = 1'b1;
				rd_addr = AW'(1);
				state_d = S_CK1;
			end
			S_CK1: begin
				cmd.set_lo = 1'b1;
				if (sts.q_le) begin
					cmd.take_clamp = 1'b1;
					state_d        = S_OUT;
				end else begin
					state_d = S_RDK;
				end
			end
			S_RDK: begin
				cmd.rd  = 1'b1;
				rd_addr = AW'(n_keys - NW'(2));
				state_d = S_CKK;
			end
			S_CKK: begin
				if (sts.q_ge) begin
					cmd.take_clamp = 1'b1;
					state_d        = S_OUT;
				end else begin
					seg_d   = AW'(1);
					state_d = S_RDS;
				end
			end
			S_RDS: begin
				cmd.rd  = 1'b1;
				rd_addr = seg_q + AW'(1);
				state_d = S_CKS;
			end
			S_CKS: begin
				if (more_seg) begin
					cmd.set_lo = 1'b1;
					seg_d      = seg_q + AW'(1);
					state_d    = S_RDS;
				end else begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				// taps are fetched and summed while the divider runs
				cmd.div_step = 1'b1;
				if (cnt_q < 4'd4) begin
					cmd.rd  = 1'b1;
					rd_addr = seg_q - AW'(1) + AW'(cnt_q[1:0]);
				end
				if (cnt_q >= 4'd1 && cnt_q <= 4'd4) begin
					cmd.acc_en  = 1'b1;
					cmd.acc_tap = 2'(cnt_q - 4'd1);
				end
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					val_d   = '0;
					state_d = S_HLD;
				end
			end
			S_HLD: begin
				cmd.h_load = 1'b1;
				stg_d      = '0;
				state_d    = S_HMUL;
			end
			S_HMUL: begin
				cmd.h_mul = 1'b1;
				state_d   = S_HADD;
			end
			S_HADD: begin
				cmd.h_add = 1'b1;
				if (stg_q == 2'd2) begin
					if (val_q == 2'd2) begin
						state_d = S_OUT;
					end else begin
						val_d   = val_q + 2'd1;
						state_d = S_HLD;
					end
				end else begin
					stg_d   = stg_q + 2'd1;
					state_d = S_HMUL;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.publish = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			seg_q       <= '0;
			cnt_q       <= '0;
			val_q       <= '0;
			stg_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			seg_q       <= seg_d;
			cnt_q       <= cnt_d;
			val_q       <= val_d;
			stg_q       <= stg_d;
		end
	end

endmodule

/* rtl/keyframe_catmull_rom_interpolator.sv */
// keyframe catmull-rom interpolator: load items are taken back to back; a query result is
// valid soonest if clamped at key 1, later if clamped at key n-2, else later still with each
// extra search step, plus any output stall; the next item is taken once the result is published;
// the t divider and the 9 shared horner multiplies set the query time
// arst_n clears the sequencer, output valid and keys_in_use (to 8); keyframe tables are not
// cleared and hold nothing defined until loaded; depends on kcri_pkg, kcri_ctrl and kcri_dp
module keyframe_catmull_rom_interpolator #(
	parameter int MAX_KEYS   = kcri_pkg::MAX_KEYS_DEF,
	parameter int VALUE_BITS = kcri_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: keys_in_use
	input  logic                              cfg_we,
	input  logic [3:0]                        cfg_wdata,
	// input item channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [2:0]                        key_index,
	input  logic signed [kcri_pkg::KEY_W-1:0] key_position,
	input  logic signed [kcri_pkg::KEY_W-1:0] key_radius_x,
	input  logic signed [kcri_pkg::KEY_W-1:0] key_radius_y,
	input  logic signed [kcri_pkg::KEY_W-1:0] key_offset_y,
	input  logic signed [kcri_pkg::KEY_W-1:0] query_pos,
	// result item channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [kcri_pkg::KEY_W-1:0] radius_x,
	output logic signed [kcri_pkg::KEY_W-1:0] radius_y,
	output logic signed [kcri_pkg::KEY_W-1:0] offset_y,
	output logic                              clamped
);
	localparam int AW = $clog2(MAX_KEYS);
	localparam int NW = $clog2(MAX_KEYS + 1);
	localparam logic [3:0] KEYS_RST = 4'd8;
	localparam logic [3:0] KEYS_MIN = 4'd4;

	logic [3:0]     keys_in_use_q;
	logic [NW-1:0]  n_keys;
	kcri_pkg::cmd_t cmd;
	kcri_pkg::sts_t sts;
	logic [AW-1:0]  rd_addr;

	// keys_in_use register, to be written only while the block is idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_in_use_q <= KEYS_RST;
		end else if (cfg_we) begin
			keys_in_use_q <= cfg_wdata;
		end
	end

	// keys actually used: held between four and the table depth
	always_comb begin
		if (keys_in_use_q < KEYS_MIN) begin
			n_keys = NW'(KEYS_MIN);
		end else if (32'(keys_in_use_q) > MAX_KEYS) begin
			n_keys = NW'(MAX_KEYS);
		end else begin
			n_keys = NW'(keys_in_use_q);
		end
	end

	// sequencer: range check, segment search, divider and horner steps
	kcri_ctrl #(
		.MAX_KEYS (MAX_KEYS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_keys    (n_keys),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.sts       (sts)
	);

	// tables, t divider, coefficient build-up, shared multiplier and output register
	kcri_dp #(
		.MAX_KEYS   (MAX_KEYS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.sts          (sts),
		.key_index    (key_index),
		.key_position (key_position),
		.key_radius_x (key_radius_x),
		.key_radius_y (key_radius_y),
		.key_offset_y (key_offset_y),
		.query_pos    (query_pos),
		.radius_x     (radius_x),
		.radius_y     (radius_y),
		.offset_y     (offset_y),
		.clamped      (clamped)
	);

endmodule

/* bench/tb_keyframe_catmull_rom_interpolator.sv */
// testbench for the keyframe catmull-rom interpolator: loads keyframes, queries positions
// and checks every result against a predictor of its own; depends on kcri_pkg and the rtl
module tb_keyframe_catmull_rom_interpolator;

	localparam int NKEYS = kcri_pkg::MAX_KEYS_DEF;

	typedef enum logic {KIND_QUERY = 1'b0, KIND_LOAD = 1'b1} kind_e;

	typedef struct packed {
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic signed [15:0] yo;
		logic               cl;
	} interp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd8;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [2:0] key_index = '0;
	logic signed [15:0] key_position = '0, key_radius_x = '0, key_radius_y = '0;
	logic signed [15:0] key_offset_y = '0, query_pos = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] radius_x, radius_y, offset_y;
	logic clamped;

	// predictor copy of the keyframe tables and the register
	kcri_pkg::key_t keyframes[NKEYS];
	int   keys_used = 8;

	interp_t expected_results[$];
	int  errors = 0;
	bit  sink_idle_ok = 1'b1;   // random stalls on the result side allowed
	bit  src_idle_ok = 1'b1;
	bit  hold_sink = 1'b0;      // long hold-off on the result side

	keyframe_catmull_rom_interpolator uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	// floor division by 2^sh
	function automatic longint fdiv(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic logic signed [15:0] cubic(longint t, longint p0, longint p1,
			longint p2, longint p3);
		longint a, b, c, d, acc;
		a = 2 * p1;
		b = p2 - p0;
		c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		d = -p0 + 3 * p1 - 3 * p2 + p3;
		acc = c + fdiv(d * t, 16);
		acc = b + fdiv(acc * t, 16);
		acc = a + fdiv(acc * t, 16);
		acc = fdiv(acc, 1);
		if (acc > 32767) acc = 32767;
		if (acc < -32768) acc = -32768;
		return 16'(acc);
	endfunction

	function automatic interp_t interpolate(logic signed [15:0] q);
		interp_t r;
		int n, seg;
		longint num, den, t;
		n = keys_used < 4 ? 4 : (keys_used > NKEYS ? NKEYS : keys_used);
		r.cl = 1'b1;
		if (q <= keyframes[1].pos) begin
			r.rx = keyframes[1].rx; r.ry = keyframes[1].ry; r.yo = keyframes[1].yo;
			return r;
		end
		if (q >= keyframes[n-2].pos) begin
			r.rx = keyframes[n-2].rx; r.ry = keyframes[n-2].ry; r.yo = keyframes[n-2].yo;
			return r;
		end
		seg = 1;
		while (seg < n - 3 && q > keyframes[seg+1].pos) seg++;
		num = longint'(q) - longint'(keyframes[seg].pos);
		den = longint'(keyframes[seg+1].pos) - longint'(keyframes[seg].pos);
		if (den <= 0 || num <= 0) t = 0;
		else begin
			t = (num * 65536) / den;
			if (t > 65535) t = 65535;
		end
		r.cl = 1'b0;
		r.rx = cubic(t, keyframes[seg-1].rx, keyframes[seg].rx, keyframes[seg+1].rx,
			keyframes[seg+2].rx);
		r.ry = cubic(t, keyframes[seg-1].ry, keyframes[seg].ry, keyframes[seg+1].ry,
			keyframes[seg+2].ry);
		r.yo = cubic(t, keyframes[seg-1].yo, keyframes[seg].yo, keyframes[seg+1].yo,
			keyframes[seg+2].yo);
		return r;
	endfunction

	// random idle gap with valid low, sometimes none
	task automatic source_gap();
		int n;
		if (src_idle_ok && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(17, 1);
			repeat (n) @(posedge clk);
		end
	endtask

	// offer one item and wait until it is accepted
	task automatic send_item(kind_e k, logic [2:0] idx, kcri_pkg::key_t kf,
			logic signed [15:0] q);
		in_valid <= 1'b1;
		kind <= k;
		key_index <= idx;
		key_position <= kf.pos;
		key_radius_x <= kf.rx;
		key_radius_y <= kf.ry;
		key_offset_y <= kf.yo;
		query_pos <= q;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (k == KIND_LOAD) begin
			keyframes[idx] = kf;
		end else
			expected_results.push_back(interpolate(q));
		source_gap();
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(logic [2:0] idx, kcri_pkg::key_t kf);
		send_item(KIND_LOAD, idx, kf, 16'($urandom));
	endtask

	task automatic query(logic signed [15:0] q);
		kcri_pkg::key_t junk;
		junk = {$urandom, $urandom};
		send_item(KIND_QUERY, 3'($urandom), junk, q);
	endtask

	// wait until nothing is expected, then let the block settle
	task automatic drain();
		int guard;
		drop_valid();
		guard = 0;
		while (expected_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_keys_used(int v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= 4'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		keys_used = v;
		@(posedge clk);
	endtask

	function automatic kcri_pkg::key_t rand_key();
		kcri_pkg::key_t kf;
		kf = {$urandom, $urandom};
		return kf;
	endfunction

	// ordered positions: even spacing if wide, else random spacing, some small values
	task automatic load_ordered_set(bit wide);
		kcri_pkg::key_t kf;
		int p;
		p = wide ? -32768 : $urandom_range(4000) - 16000;
		for (int i = 0; i < NKEYS; i++) begin
			kf = rand_key();
			if (!wide && $urandom_range(1)) begin
				kf.rx = 16'($urandom_range(8000) - 4000);
				kf.ry = 16'($urandom_range(8000) - 4000);
				kf.yo = 16'($urandom_range(8000) - 4000);
			end
			kf.pos = 16'(p);
			load_key(3'(i), kf);
			p = p + (wide ? 9362 : $urandom_range(4000));
			if (p > 32767) p = 32767;
		end
	endtask

	function automatic logic signed [15:0] pos_near_keys();
		int k, v;
		k = $urandom_range(NKEYS - 1);
		case ($urandom_range(4))
			0: return 16'($urandom);
			1: return keyframes[k].pos;
			default: begin
				v = keyframes[k].pos + int'($urandom_range(600)) - 300;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				return 16'(v);
			end
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		interp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (radius_x !== e.rx) begin
					$error("radius_x expected %0d actual %0d", e.rx, radius_x); errors++;
				end
				if (radius_y !== e.ry) begin
					$error("radius_y expected %0d actual %0d", e.ry, radius_y); errors++;
				end
				if (offset_y !== e.yo) begin
					$error("offset_y expected %0d actual %0d", e.yo, offset_y); errors++;
				end
				if (clamped !== e.cl) begin
					$error("clamped expected %0b actual %0b", e.cl, clamped); errors++;
				end
			end
		end
	end

	// result side stalls in bursts, or a long hold-off when asked
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_stall <= 1'b1;
				n = 0;
				while (n < 400) begin
					@(posedge clk);
					n++;
				end
				out_stall <= 1'b0;
				hold_sink = 1'b0;
			end else if (sink_idle_ok && $urandom_range(3) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(17, 1);
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// extremes of every field, both clamping sides and a zero-length segment
	task automatic test_directed();
		kcri_pkg::key_t kf;
		load_ordered_set(1'b1);
		kf = '{pos: 16'sh8000, rx: 16'sh8000, ry: 16'sh7FFF, yo: 16'sh8000};
		load_key(3'd0, kf);
		kf = '{pos: -16'sd20000, rx: 16'sh7FFF, ry: 16'sh8000, yo: 16'sh7FFF};
		load_key(3'd1, kf);
		kf = '{pos: 16'sd0, rx: 16'sh8000, ry: 16'sh7FFF, yo: 16'sd0};
		load_key(3'd2, kf);
		kf = '{pos: 16'sh7FFF, rx: 16'sh7FFF, ry: 16'sh8000, yo: 16'shFFFF};
		load_key(3'd7, kf);
		query(16'sh8000);
		query(16'sh7FFF);
		query(-16'sd20000);
		query(-16'sd19999);
		query(16'sd0);
		query(16'sd1);
		query(keyframes[6].pos);
		query(keyframes[6].pos - 16'sd1);
		query(16'sh5555);
		query(16'shAAAA);
		drain();
		// equal positions make a zero-length segment
		kf = keyframes[3]; kf.pos = keyframes[2].pos;
		load_key(3'd3, kf);
		query(keyframes[2].pos + 16'sd1);
		query(keyframes[2].pos);
	endtask

	task automatic test_keys_used();
		int settings[6] = '{4, 8, 0, 15, 5, 7};
		foreach (settings[s]) begin
			write_keys_used(settings[s]);
			load_ordered_set($urandom_range(1));
			for (int i = 0; i < 60; i++) query(pos_near_keys());
		end
		write_keys_used(8);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) load_key(3'($urandom), rand_key());
			else if ($urandom_range(40) == 0) load_ordered_set($urandom_range(1));
			else query(pos_near_keys());
		end
	endtask

	// block fills and stalls its input while results are held back
	task automatic test_backpressure();
		hold_sink = 1'b1;
		for (int i = 0; i < 20; i++) query(pos_near_keys());
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_keys_used();
		test_backpressure();
		test_random(600);
		drain();
		test_random(300);
		// last part runs with no idling on either side
		sink_idle_ok = 1'b0;
		src_idle_ok = 1'b0;
		test_random(250);
		drain();
		if (errors == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else begin
			if (expected_results.size() != 0)
				$error("%0d result items never arrived", expected_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/kcri_pkg.sv
rtl/kcri_dp.sv
rtl/kcri_ctrl.sv
rtl/keyframe_catmull_rom_interpolator.sv
bench/tb_keyframe_catmull_rom_interpolator.sv
